// File: hdl/lru_block_cache_lookup_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU block cache lookup
// Shared property wrappers clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_LOOKUP_ASSERT_SVH
`define LRU_BLOCK_CACHE_LOOKUP_ASSERT_SVH

// check a property outside of reset
`define LBC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check a property on every clock edge
`define LBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: hdl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup package
// Sizes, payload types and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int FILE_W  = 32;
    localparam int OFF_W   = 31;
    localparam int SLOT_W  = 4;
    localparam int LIMIT_W = 5;

    typedef logic [FILE_W-1:0]  t_file;
    typedef logic [OFF_W-1:0]   t_off;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    localparam t_limit LIMIT_RESET = t_limit'(16);

    typedef struct packed {
        logic load;    // capture the request key
        logic match;   // register the tag compare and victim search
        logic commit;  // update the directory and load the result
    } t_cmd;

endpackage

// File: hdl/lbc_if.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup channels
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface lbc_req_if;
    logic          valid;
    logic          ready;
    lbc_pkg::t_file file_number;
    lbc_pkg::t_off  block_offset;
    logic          fill_ok;

    modport source (output valid, output file_number, output block_offset,
                    output fill_ok, input ready);
    modport sink   (input valid, input file_number, input block_offset,
                    input fill_ok, output ready);
endinterface

interface lbc_rsp_if;
    logic           valid;
    logic           ready;
    logic           hit;
    lbc_pkg::t_slot slot;
    logic           inserted;
    logic           evicted;
    lbc_pkg::t_file victim_file;
    lbc_pkg::t_off  victim_offset;

    modport source (output valid, output hit, output slot, output inserted,
                    output evicted, output victim_file, output victim_offset,
                    input ready);
    modport sink   (input valid, input hit, input slot, input inserted,
                    input evicted, input victim_file, input victim_offset,
                    output ready);
endinterface

interface lbc_cfg_if;
    logic            valid;
    logic            ready;
    lbc_pkg::t_limit data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup controller
// Sequences accept, match and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lbc_pkg::t_cmd o_cmd
);
    import lbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   can_commit;
    logic   accept;

    assign can_commit = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_UPDATE) && can_commit);
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.load   = accept;
    assign o_cmd.match  = (r_state == S_MATCH);
    assign o_cmd.commit = (r_state == S_UPDATE) && can_commit;

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                // hold until the result register can take the new result
                if (can_commit) n_state = accept ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/lbc_datapath.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup datapath
// Directory storage, tag compare, recency ranks, eviction and fill.
// ----------------------------------------------------------------------------
`include "lru_block_cache_lookup_assert.svh"

module lbc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lbc_pkg::t_cmd   i_cmd,
    input  logic            i_cfg_we,
    input  lbc_pkg::t_limit i_cfg_data,
    input  lbc_pkg::t_file  i_file,
    input  lbc_pkg::t_off   i_off,
    input  logic            i_fill,
    output logic            o_hit,
    output lbc_pkg::t_slot  o_slot,
    output logic            o_ins,
    output logic            o_ev,
    output lbc_pkg::t_file  o_vfile,
    output lbc_pkg::t_off   o_voff
);
    import lbc_pkg::*;

    // directory
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_idx               r_rank [ENTRIES];
    t_idx               n_rank [ENTRIES];
    t_file              r_file [ENTRIES];
    t_off               r_offs [ENTRIES];
    t_cnt               r_occ, n_occ;
    t_limit             r_limit;

    // request key
    t_file r_key_file;
    t_off  r_key_off;
    logic  r_key_fill;

    // match stage
    logic [ENTRIES-1:0] match, victim;
    logic [ENTRIES-1:0] r_match, r_victim;
    logic               r_evict;
    logic               need_evict;

    // result register
    logic  r_hit, r_ins, r_ev;
    t_slot r_slot;
    t_file r_vfile;
    t_off  r_voff;

    // update stage
    t_cnt               lim, lim_m1, occ_k;
    logic               hit, do_ins, has_free;
    t_idx               hit_idx, free_idx, slot_idx;
    t_idx               hit_rank;
    logic [ENTRIES-1:0] keep;
    t_file              vfile;
    t_off               voff;

    // a zero limit acts as one, a limit past the table as the table size
    always_comb begin
        if (r_limit == '0) begin
            lim = t_cnt'(1);
        end else if (int'(r_limit) > ENTRIES) begin
            lim = t_cnt'(ENTRIES);
        end else begin
            lim = t_cnt'(r_limit);
        end
        lim_m1 = lim - t_cnt'(1);
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_file[i] == r_key_file) && (r_offs[i] == r_key_off);
            // least recent entry holds rank occupancy - 1
            victim[i] = r_valid[i] && (t_cnt'(r_rank[i]) == (r_occ - t_cnt'(1)));
        end
        need_evict = (r_occ >= lim);
    end

    always_comb begin
        hit      = |r_match;
        hit_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) hit_idx = t_idx'(i);
        end
        hit_rank = r_rank[hit_idx];

        // evicting every rank at or above limit - 1 drops the excess in one go
        for (int i = 0; i < ENTRIES; i++) begin
            keep[i] = r_valid[i] && !(r_evict && (t_cnt'(r_rank[i]) >= lim_m1));
        end
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!keep[i]) free_idx = t_idx'(i);
        end
        has_free = !(&keep);
        do_ins   = !hit && r_key_fill && has_free;
        occ_k    = r_evict ? lim_m1 : r_occ;

        vfile = '0;
        voff  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_evict && r_victim[i]) begin
                vfile = vfile | r_file[i];
                voff  = voff | r_offs[i];
            end
        end

        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < hit_rank)) n_rank[i] = r_rank[i] + t_idx'(1);
            end
            n_rank[hit_idx] = '0;
        end else begin
            n_valid = keep;
            n_occ   = occ_k;
            if (do_ins) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (keep[i]) n_rank[i] = r_rank[i] + t_idx'(1);
                end
                n_rank[free_idx]  = '0;
                n_valid[free_idx] = 1'b1;
                n_occ             = occ_k + t_cnt'(1);
            end
        end

        if (hit) begin
            slot_idx = hit_idx;
        end else if (do_ins) begin
            slot_idx = free_idx;
        end else begin
            slot_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_limit <= LIMIT_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (i_cmd.commit) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_file <= i_file;
            r_key_off  <= i_off;
            r_key_fill <= i_fill;
        end
        if (i_cmd.match) begin
            r_match  <= match;
            r_victim <= victim;
            r_evict  <= !(|match) && need_evict;
        end
        if (i_cmd.commit) begin
            if (do_ins) begin
                r_file[free_idx] <= r_key_file;
                r_offs[free_idx] <= r_key_off;
            end
            r_hit   <= hit;
            r_slot  <= t_slot'(slot_idx);
            r_ins   <= do_ins;
            r_ev    <= r_evict;
            r_vfile <= vfile;
            r_voff  <= voff;
        end
    end

    assign o_hit   = r_hit;
    assign o_slot  = r_slot;
    assign o_ins   = r_ins;
    assign o_ev    = r_ev;
    assign o_vfile = r_vfile;
    assign o_voff  = r_voff;

    `LBC_ASSERT_RST(a_occ_tracks_valid, $countones(r_valid) == int'(r_occ), "occupancy out of step with valid bits")
    `LBC_ASSERT_RST(a_match_unique, i_cmd.commit |-> $onehot0(r_match), "key held in more than one slot")
    `LBC_ASSERT_RST(a_victim_unique, (i_cmd.commit && r_evict) |-> $onehot(r_victim), "least recent entry not unique")
    `LBC_ASSERT_RST(a_insert_lands, (i_cmd.commit && do_ins) |=> r_valid[$past(free_idx)], "inserted slot not valid")

endmodule

// File: hdl/lru_block_cache_lookup.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup
// Fully associative block directory with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request has a match cycle that compares the key against
// all 16 entries and finds the least recent one, then an update cycle that
// rewrites the recency ranks, the valid bits and the slot, and loads the
// result register. A new request is taken during the update cycle, once
// the result register is free, so one lookup can overlap the next. The
// update cycle waits while an earlier result is still held. The user must
// write the capacity limit through the configuration channel only while
// no request is in flight; the block itself does not enforce this.
module lru_block_cache_lookup (
    input logic      i_clk,
    input logic      i_rst_n,
    lbc_req_if.sink   i_req,
    lbc_rsp_if.source o_rsp,
    lbc_cfg_if.sink   i_cfg
);
    import lbc_pkg::*;

    t_cmd cmd;

    assign i_cfg.ready = 1'b1;

    lbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lbc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_file     (i_req.file_number),
        .i_off      (i_req.block_offset),
        .i_fill     (i_req.fill_ok),
        .o_hit      (o_rsp.hit),
        .o_slot     (o_rsp.slot),
        .o_ins      (o_rsp.inserted),
        .o_ev       (o_rsp.evicted),
        .o_vfile    (o_rsp.victim_file),
        .o_voff     (o_rsp.victim_offset)
    );

endmodule

// File: sim/lbc_directory_checker.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup checker
// Watches the request, response and limit channels, keeps a shadow copy of
// the directory and its recency order, and compares every response against
// the oldest predicted lookup result.
// ----------------------------------------------------------------------------
module lbc_directory_checker
    import lbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lbc_req_if   i_req,
    lbc_rsp_if   i_rsp,
    lbc_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits
);

    typedef struct packed {
        logic  hit;
        t_slot slot;
        logic  inserted;
        logic  evicted;
        t_file victim_file;
        t_off  victim_offset;
    } t_lookup_result;

    // shadow directory
    logic   dir_valid [ENTRIES];
    t_file  dir_file  [ENTRIES];
    t_off   dir_off   [ENTRIES];
    int     dir_rank  [ENTRIES];
    int     fill_count;
    t_limit limit_reg;

    t_lookup_result results_due[$];
    t_lookup_result due;
    t_lookup_result seen;
    int             mismatch_count;
    int             checked_count;
    int             hit_count;

    function automatic t_lookup_result predict_lookup(t_file key_file, t_off key_off,
                                                      logic fill);
        t_lookup_result res;
        int i;
        int found;
        int victim;
        int free_slot;
        int rank;
        int lim;
        res   = '0;
        found = -1;
        for (i = 0; i < ENTRIES; i++) begin
            if (found < 0 && dir_valid[i] && dir_file[i] == key_file && dir_off[i] == key_off)
                found = i;
        end
        if (found >= 0) begin
            // promote the hit entry, age everything that was more recent
            rank = dir_rank[found];
            for (i = 0; i < ENTRIES; i++) begin
                if (dir_valid[i] && dir_rank[i] < rank)
                    dir_rank[i]++;
            end
            dir_rank[found] = 0;
            res.hit  = 1'b1;
            res.slot = t_slot'(found);
        end else begin
            lim = int'(limit_reg);
            if (lim == 0)
                lim = 1;
            if (lim > ENTRIES)
                lim = ENTRIES;
            // drop least recent entries until below the limit; report the first
            while (fill_count >= lim) begin
                victim = -1;
                for (i = 0; i < ENTRIES; i++) begin
                    if (dir_valid[i] && (victim < 0 || dir_rank[i] > dir_rank[victim]))
                        victim = i;
                end
                if (victim < 0) begin
                    fill_count = 0;
                    break;
                end
                if (!res.evicted) begin
                    res.evicted       = 1'b1;
                    res.victim_file   = dir_file[victim];
                    res.victim_offset = dir_off[victim];
                end
                dir_valid[victim] = 1'b0;
                fill_count--;
            end
            if (fill) begin
                free_slot = -1;
                for (i = 0; i < ENTRIES; i++) begin
                    if (free_slot < 0 && !dir_valid[i])
                        free_slot = i;
                end
                if (free_slot >= 0) begin
                    for (i = 0; i < ENTRIES; i++) begin
                        if (dir_valid[i])
                            dir_rank[i]++;
                    end
                    dir_valid[free_slot] = 1'b1;
                    dir_file[free_slot]  = key_file;
                    dir_off[free_slot]   = key_off;
                    dir_rank[free_slot]  = 0;
                    fill_count++;
                    res.inserted = 1'b1;
                    res.slot     = t_slot'(free_slot);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                dir_valid[i] = 1'b0;
                dir_file[i]  = '0;
                dir_off[i]   = '0;
                dir_rank[i]  = 0;
            end
            fill_count = 0;
            limit_reg  = LIMIT_RESET;
            results_due.delete();
            mismatch_count = 0;
            checked_count  = 0;
            hit_count      = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                limit_reg = i_cfg.data;
            if (i_req.valid && i_req.ready)
                results_due.push_back(predict_lookup(i_req.file_number, i_req.block_offset,
                                                     i_req.fill_ok));
            if (i_rsp.valid && i_rsp.ready) begin
                seen.hit           = i_rsp.hit;
                seen.slot          = i_rsp.slot;
                seen.inserted      = i_rsp.inserted;
                seen.evicted       = i_rsp.evicted;
                seen.victim_file   = i_rsp.victim_file;
                seen.victim_offset = i_rsp.victim_offset;
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: response with no lookup outstanding: hit=%0d slot=%0d",
                                 seen.hit, seen.slot);
                end else begin
                    due = results_due.pop_front();
                    checked_count++;
                    if (due.hit)
                        hit_count++;
                    if (seen.hit !== due.hit || seen.slot !== due.slot ||
                        seen.inserted !== due.inserted || seen.evicted !== due.evicted ||
                        seen.victim_file !== due.victim_file ||
                        seen.victim_offset !== due.victim_offset) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("ERROR: lookup %0d expected hit=%0d slot=%0d ins=%0d ev=%0d victim=%h/%h",
                                     checked_count, due.hit, due.slot, due.inserted,
                                     due.evicted, due.victim_file, due.victim_offset);
                            $display("       lookup %0d got      hit=%0d slot=%0d ins=%0d ev=%0d victim=%h/%h",
                                     checked_count, seen.hit, seen.slot, seen.inserted,
                                     seen.evicted, seen.victim_file, seen.victim_offset);
                        end
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= results_due.size();
        o_checked    <= checked_count;
        o_hits       <= hit_count;
    end

endmodule

// File: sim/lru_block_cache_lookup_tb.sv
// ----------------------------------------------------------------------------
// LRU block cache lookup testbench
// Drives directed and random lookups through several capacity limits with
// random gaps on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module lru_block_cache_lookup_tb;
    import lbc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 113;

    typedef struct packed {
        t_file file_number;
        t_off  block_offset;
    } t_key;

    logic i_clk;
    logic i_rst_n;

    lbc_req_if req_ch();
    lbc_rsp_if rsp_ch();
    lbc_cfg_if cfg_ch();

    int mismatches;
    int pending;
    int checked;
    int hits;

    int     send_pace;
    int     drain_pace;
    int     rsp_stall;
    int     cycle_count;
    int     lookups_sent;
    int     limit_writes;
    t_key   recent_keys[$];
    t_file  pool_file[6];
    t_off   pool_off[5];
    t_limit phase_limits[6] = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd2, 5'd17};

    lru_block_cache_lookup u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    lbc_directory_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // pace 0: back to back, 1: short gaps, 2: longer random gaps
    function automatic int pick_wait(int pace);
        case (pace)
            0: return 0;
            1: return $urandom_range(0, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    task automatic send_lookup(input t_file file_number, input t_off block_offset,
                               input logic fill_ok);
        int gap;
        gap = pick_wait(send_pace);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.file_number  <= file_number;
        req_ch.block_offset <= block_offset;
        req_ch.fill_ok      <= fill_ok;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        recent_keys.push_back({file_number, block_offset});
        if (recent_keys.size() > 6)
            void'(recent_keys.pop_front());
        lookups_sent++;
    endtask

    task automatic random_lookup();
        int   pick;
        t_key key;
        logic fill;
        pick = $urandom_range(0, 99);
        if (pick < 35 && recent_keys.size() > 0) begin
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end else if (pick < 85) begin
            key.file_number  = pool_file[$urandom_range(0, 5)];
            key.block_offset = pool_off[$urandom_range(0, 4)];
        end else begin
            key.file_number  = $urandom;
            key.block_offset = t_off'($urandom);
        end
        fill = ($urandom_range(0, 9) != 0);
        send_lookup(key.file_number, key.block_offset, fill);
    endtask

    // hold off until every lookup has answered, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_limit value);
        drain();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        limit_writes++;
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d lookups outstanding", cycle_count, pending);
        $display("Some tests failed");
        $finish;
    end

    initial begin : response_sink
        rsp_ch.ready = 1'b0;
        forever begin
            rsp_stall = pick_wait(drain_pace);
            @(negedge i_clk);
            if (rsp_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && i_rst_n)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int     i;
        int     phase;
        int     pace_left;
        t_limit limit;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.file_number  = '0;
        req_ch.block_offset = '0;
        req_ch.fill_ok      = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        send_pace           = 0;
        drain_pace          = 0;
        lookups_sent        = 0;
        limit_writes        = 0;
        pool_file[0] = '0;
        pool_file[1] = '1;
        pool_off[0]  = '0;
        pool_off[1]  = '1;
        for (i = 2; i < 6; i++)
            pool_file[i] = $urandom;
        for (i = 2; i < 5; i++)
            pool_off[i] = t_off'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme keys, hit after insert, failed fill, partial key match
        send_lookup('0, '0, 1'b1);
        send_lookup('1, '1, 1'b1);
        send_lookup('0, '0, 1'b1);
        send_lookup(32'h5A5A_5A5A, 31'h2A5A_5A5A, 1'b0);
        send_lookup('1, '1, 1'b0);
        send_lookup('0, '1, 1'b1);
        send_lookup('1, '0, 1'b1);
        // fill the table, then miss at full capacity
        for (i = 1; i <= 12; i++)
            send_lookup(t_file'(i), t_off'(i), 1'b1);
        send_lookup(32'h1234_5678, 31'h5555_5555, 1'b1);
        // lower the limit on a full table: one miss evicts many entries
        write_limit(t_limit'(3));
        send_lookup(32'hDEAD_BEEF, 31'h0BAD_F00D, 1'b1);
        send_lookup(32'hCAFE_0001, 31'h0000_0001, 1'b0);
        // a limit of zero behaves as one
        write_limit(t_limit'(0));
        send_lookup(32'h8000_0000, 31'h4000_0000, 1'b1);
        send_lookup(32'h8000_0000, 31'h4000_0000, 1'b1);
        // a limit above the table size behaves as the full table
        write_limit(t_limit'(31));
        send_lookup(32'h0000_0001, 31'h7FFF_FFFE, 1'b1);

        // random phases, each under its own limit
        pace_left = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 6)
                limit = phase_limits[phase];
            else
                limit = t_limit'($urandom_range(0, 31));
            write_limit(limit);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (pace_left <= 0) begin
                    send_pace  = $urandom_range(0, 2);
                    drain_pace = $urandom_range(0, 2);
                    pace_left  = $urandom_range(15, 60);
                end
                pace_left--;
                random_lookup();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d lookups under %0d limit settings; %0d results checked, %0d hits.",
                 lookups_sent, limit_writes + 1, checked, hits);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
